>>> rtl/tsru_pkg.sv
package tsru_pkg;

	// Geometry and fixed-point format
	localparam int ROWS       = 63;
	localparam int COLS       = 1024;
	localparam int FRAC_BITS  = 8;
	localparam int SLOPE_FRAC = 16;

	localparam int XW   = 18;
	localparam int YW   = 14;
	localparam int ROWW = 6;
	localparam int COLW = $clog2(COLS);

	localparam logic [XW-1:0] XLIM = XW'((COLS - 1) << FRAC_BITS);
	localparam logic [YW-1:0] YLIM = YW'((ROWS - 1) << FRAC_BITS);

	// Divider: |dx| << SLOPE_FRAC over dy
	localparam int DVD_W = XW + SLOPE_FRAC;
	localparam int CNT_W = $clog2(DVD_W + 1);

	// Edge evaluation widths
	localparam int SLW = DVD_W + 1;   // signed slope
	localparam int DW  = YW + 2;      // signed row offset
	localparam int PW  = SLW + DW;    // product
	localparam int VW  = PW + 1;      // edge x, signed
	localparam int UW  = VW - 1;      // edge x, clamped at zero
	localparam int SH  = FRAC_BITS + SLOPE_FRAC;

	typedef struct packed {
		logic [XW-1:0] ax;
		logic [YW-1:0] ay;
		logic [XW-1:0] bx;
		logic [YW-1:0] by;
		logic [XW-1:0] cx;
		logic [YW-1:0] cy;
	} vtx_item_t;

	typedef struct packed {
		logic [ROWW-1:0] span_row;
		logic [COLW-1:0] span_start;
		logic [COLW-1:0] span_end;
		logic            span_last;
	} span_item_t;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_SORT    = 7'b0000010,
		S_DIVGO   = 7'b0000100,
		S_DIVWAIT = 7'b0001000,
		S_ROWINIT = 7'b0010000,
		S_MUL     = 7'b0100000,
		S_EMIT    = 7'b1000000
	} state_t;

endpackage

>>> rtl/tsru_div.sv
module tsru_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tsru_pkg::DVD_W-1:0] dividend,
	input  logic [tsru_pkg::YW-1:0]    divisor,
	output logic                      busy,
	output logic [tsru_pkg::DVD_W-1:0] quot
);
	import tsru_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quot_q;
	logic [YW-1:0]    rem_q;
	logic [YW-1:0]    div_q;
	logic [YW:0]      trial;
	logic [YW:0]      diff;
	logic             ge;

	// One restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quot_q[DVD_W-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[YW-1:0] : trial[YW-1:0];
			quot_q <= {quot_q[DVD_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

>>> rtl/triangle_span_rasterizer_unit.sv
// channel | dir | handshake               | payload
// vtx     | in  | vtx_valid / vtx_ready   | vtx_item_t: three vertices
// span    | out | span_valid / span_ready | span_item_t: row, start, end, last
//
// One triangle at a time; vtx_ready is high only while idle.
// Setup: load, sort, then per slope a pass through the shared bit-serial
// divider (skipped for a horizontal edge).
// Rows: each row is a multiply step, then an add/compare step; each half
// starts with a row-init step.
// A span waits one stage so the final one can be flagged; a full output
// register stalls the row loop. Reset clears all control state.
module triangle_span_rasterizer_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   vtx_valid,
	output logic                   vtx_ready,
	input  tsru_pkg::vtx_item_t    vtx,
	output logic                   span_valid,
	input  logic                   span_ready,
	output tsru_pkg::span_item_t   span
);
	import tsru_pkg::*;

	state_t state_q;

	logic [XW-1:0]   vx_q [3];
	logic [YW-1:0]   vy_q [3];
	logic [SLW-1:0]  slope_q [3];
	logic [1:0]      step_q;
	logic [1:0]      k_q;
	logic            neg_q;
	logic            half_q;
	logic [ROWW-1:0] row_q;
	logic [ROWW-1:0] lim_q;
	logic signed [PW-1:0] prod_e_q;
	logic signed [PW-1:0] prod_l_q;

	logic       pend_v_q;
	span_item_t pend_q;
	logic       out_v_q;
	span_item_t out_q;

	// divider link
	logic             div_start;
	logic             div_busy;
	logic [DVD_W-1:0] div_quot;
	logic [DVD_W-1:0] dvd;
	logic [YW-1:0]    dy;

	// operand selection
	logic [XW-1:0] xa, xb, xe;
	logic [YW-1:0] ya, yb, ye, ylo, yhi;
	logic [SLW-1:0] se;
	logic signed [XW:0] dx;
	logic [XW-1:0]  mag;
	logic signed [DW-1:0] d_e, d_l;
	logic signed [VW-1:0] va, vb;
	logic [UW-1:0] ua, ub, lo, hi;
	logic [UW:0]   lo_up;
	logic [UW-SH:0] c0;
	logic [UW-SH-1:0] c1;
	logic found;
	logic out_free;
	logic out_load;
	logic [SLW-1:0] new_slope;
	span_item_t new_span;

	tsru_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dy),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	// Slope operands for edge k: 1-2, 1-3, 2-3
	always_comb begin
		unique case (k_q)
			2'd0: begin
				xa = vx_q[0]; ya = vy_q[0]; xb = vx_q[1]; yb = vy_q[1];
			end
			2'd1: begin
				xa = vx_q[0]; ya = vy_q[0]; xb = vx_q[2]; yb = vy_q[2];
			end
			default: begin
				xa = vx_q[1]; ya = vy_q[1]; xb = vx_q[2]; yb = vy_q[2];
			end
		endcase
		dx  = $signed({1'b0, xb}) - $signed({1'b0, xa});
		mag = dx[XW] ? XW'(-dx) : dx[XW-1:0];
		dvd = {mag, {SLOPE_FRAC{1'b0}}};
		dy  = yb - ya;
		div_start = (state_q == S_DIVGO) && (dy != '0);
		new_slope = neg_q ? SLW'(-{1'b0, div_quot}) : {1'b0, div_quot};
	end

	// Half selection: upper half uses edge 1-2, lower half edge 2-3
	always_comb begin
		ylo = half_q ? vy_q[1] : vy_q[0];
		yhi = half_q ? vy_q[2] : vy_q[1];
		xe  = half_q ? vx_q[1] : vx_q[0];
		ye  = half_q ? vy_q[1] : vy_q[0];
		se  = half_q ? slope_q[2] : slope_q[0];
		d_e = $signed({2'b00, row_q, {FRAC_BITS{1'b0}}}) - $signed({2'b00, ye});
		d_l = $signed({2'b00, row_q, {FRAC_BITS{1'b0}}}) - $signed({2'b00, vy_q[0]});
	end

	// Edge x, clamp at zero, then ceil/floor to columns, clipped to the last column
	always_comb begin
		va = $signed({{(VW-DVD_W){1'b0}}, xe, {SLOPE_FRAC{1'b0}}})
			+ $signed({{(VW-PW){prod_e_q[PW-1]}}, prod_e_q});
		vb = $signed({{(VW-DVD_W){1'b0}}, vx_q[0], {SLOPE_FRAC{1'b0}}})
			+ $signed({{(VW-PW){prod_l_q[PW-1]}}, prod_l_q});
		ua = va[VW-1] ? '0 : va[UW-1:0];
		ub = vb[VW-1] ? '0 : vb[UW-1:0];
		lo = (ua < ub) ? ua : ub;
		hi = (ua < ub) ? ub : ua;
		lo_up = {1'b0, lo} + {{(UW+1-SH){1'b0}}, {SH{1'b1}}};
		c0 = lo_up[UW:SH];
		c1 = hi[UW-1:SH];
		found = {1'b0, c1} >= c0;
		new_span.span_row   = row_q;
		new_span.span_start = (c0 > (UW-SH+1)'(COLS - 1)) ? COLW'(COLS - 1) : c0[COLW-1:0];
		new_span.span_end   = (c1 > (UW-SH)'(COLS - 1)) ? COLW'(COLS - 1) : c1[COLW-1:0];
		new_span.span_last  = 1'b0;
	end

	assign out_free = !out_v_q || span_ready;

	// Output register loads, when free, on a found span with one pending, or on the final flush
	assign out_load = out_free && pend_v_q
		&& (((state_q == S_EMIT) && found)
			|| ((state_q == S_MUL) && (row_q > lim_q) && half_q));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			k_q      <= '0;
			half_q   <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && span_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (vtx_valid) begin
						step_q  <= '0;
						state_q <= S_SORT;
					end
				end
				S_SORT: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd2) begin
						k_q     <= '0;
						state_q <= S_DIVGO;
					end
				end
				S_DIVGO: begin
					if (dy != '0) begin
						state_q <= S_DIVWAIT;
					end else if (k_q == 2'd2) begin
						half_q  <= 1'b0;
						state_q <= S_ROWINIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DIVWAIT: begin
					if (!div_busy) begin
						if (k_q == 2'd2) begin
							half_q  <= 1'b0;
							state_q <= S_ROWINIT;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_DIVGO;
						end
					end
				end
				S_ROWINIT: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (row_q > lim_q) begin
						if (!half_q) begin
							half_q  <= 1'b1;
							state_q <= S_ROWINIT;
						end else if (!pend_v_q) begin
							state_q <= S_IDLE;
						end else if (out_free) begin
							// final span of the triangle
							pend_v_q <= 1'b0;
							state_q  <= S_IDLE;
						end
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!found) begin
						state_q <= S_MUL;
					end else if (!pend_v_q) begin
						pend_v_q <= 1'b1;
						state_q  <= S_MUL;
					end else if (out_free) begin
						state_q <= S_MUL;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (vtx_valid) begin
					vx_q[0] <= (vtx.ax > XLIM) ? XLIM : vtx.ax;
					vy_q[0] <= (vtx.ay > YLIM) ? YLIM : vtx.ay;
					vx_q[1] <= (vtx.bx > XLIM) ? XLIM : vtx.bx;
					vy_q[1] <= (vtx.by > YLIM) ? YLIM : vtx.by;
					vx_q[2] <= (vtx.cx > XLIM) ? XLIM : vtx.cx;
					vy_q[2] <= (vtx.cy > YLIM) ? YLIM : vtx.cy;
				end
			end
			S_SORT: begin
				// compare-swap pairs 0-1, 1-2, 0-1; equal y keeps order
				if (step_q == 2'd1) begin
					if (vy_q[1] > vy_q[2]) begin
						vx_q[1] <= vx_q[2]; vx_q[2] <= vx_q[1];
						vy_q[1] <= vy_q[2]; vy_q[2] <= vy_q[1];
					end
				end else if (vy_q[0] > vy_q[1]) begin
					vx_q[0] <= vx_q[1]; vx_q[1] <= vx_q[0];
					vy_q[0] <= vy_q[1]; vy_q[1] <= vy_q[0];
				end
			end
			S_DIVGO: begin
				neg_q <= dx[XW];
				if (dy == '0) begin
					slope_q[k_q] <= '0;
				end
			end
			S_DIVWAIT: begin
				if (!div_busy) begin
					slope_q[k_q] <= new_slope;
				end
			end
			S_ROWINIT: begin
				row_q <= ROWW'((YW'(ylo) + YW'((1 << FRAC_BITS) - 1)) >> FRAC_BITS);
				lim_q <= ROWW'(yhi >> FRAC_BITS);
			end
			S_MUL: begin
				prod_e_q <= $signed(se) * d_e;
				prod_l_q <= $signed(slope_q[1]) * d_l;
				if (row_q > lim_q && half_q && pend_v_q && out_free) begin
					out_q <= '{span_row: pend_q.span_row, span_start: pend_q.span_start,
						span_end: pend_q.span_end, span_last: 1'b1};
				end
			end
			S_EMIT: begin
				if (!found) begin
					row_q <= row_q + 1'b1;
				end else if (!pend_v_q) begin
					pend_q <= new_span;
					row_q  <= row_q + 1'b1;
				end else if (out_free) begin
					out_q  <= pend_q;
					pend_q <= new_span;
					row_q  <= row_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign vtx_ready  = (state_q == S_IDLE);
	assign span_valid = out_v_q;
	assign span       = out_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("sequencer state not one-hot");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q) else $error("span left pending while idle");

	a_div_only_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == S_DIVWAIT)) else $error("divider busy outside slope wait");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid |-> (span.span_start <= span.span_end))
		else $error("span start beyond span end");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(span_valid && !span_ready) |=> (span_valid && $stable(span)))
		else $error("stalled span changed");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import tsru_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       vtx_valid;
	logic       vtx_ready;
	vtx_item_t  vtx;
	logic       span_valid;
	logic       span_ready;
	span_item_t span;

	span_item_t span_q[$];
	int         err_cnt;
	int         hold_cycles;   // receiver long hold-off, counted in its own process
	bit         rx_random;

	triangle_span_rasterizer_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.vtx_valid  (vtx_valid),
		.vtx_ready  (vtx_ready),
		.vtx        (vtx),
		.span_valid (span_valid),
		.span_ready (span_ready),
		.span       (span)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#20ms;
		$display("** triangle_span_rasterizer_unit: FAILED **");
		$finish;
	end

	// Signed slope dx/dy in Q.16, truncated toward zero
	function automatic longint edge_slope(longint xa, longint ya, longint xb, longint yb);
		longint dx;
		longint dy;
		longint q;
		dx = xb - xa;
		dy = yb - ya;
		if (dy == 0)
			return 0;
		q = ((dx < 0 ? -dx : dx) << SLOPE_FRAC) / dy;
		return dx < 0 ? -q : q;
	endfunction

	function automatic longint edge_at(longint xa, longint ya, longint sl, longint row);
		longint v;
		v = (xa << SLOPE_FRAC) + sl * ((row << FRAC_BITS) - ya);
		return v < 0 ? 0 : v;
	endfunction

	function automatic longint clip_col(longint c);
		return c > COLS - 1 ? COLS - 1 : c;
	endfunction

	// Spans of one half into the expected queue
	task automatic scan_half(longint ylo, longint yhi, longint xe, longint ye, longint se,
			longint xl, longint yl, longint sl, ref int n);
		longint     a, b, lo, hi, c0, c1, fm;
		span_item_t s;
		fm = (longint'(1) << SH) - 1;
		for (longint row = (ylo + (1 << FRAC_BITS) - 1) >> FRAC_BITS;
				row <= (yhi >> FRAC_BITS); row++) begin
			a  = edge_at(xe, ye, se, row);
			b  = edge_at(xl, yl, sl, row);
			lo = a < b ? a : b;
			hi = a < b ? b : a;
			c0 = (lo + fm) >> SH;
			c1 = hi >> SH;
			if (c1 >= c0 && n < 64) begin
				s.span_row   = ROWW'(row);
				s.span_start = COLW'(clip_col(c0));
				s.span_end   = COLW'(clip_col(c1));
				s.span_last  = 1'b0;
				span_q.push_back(s);
				n++;
			end
		end
	endtask

	// Predict the spans of one triangle
	task automatic predict_spans(vtx_item_t t);
		longint vx[3], vy[3], tmp;
		int     n;
		int     p;
		vx[0] = t.ax > XLIM ? XLIM : t.ax;
		vy[0] = t.ay > YLIM ? YLIM : t.ay;
		vx[1] = t.bx > XLIM ? XLIM : t.bx;
		vy[1] = t.by > YLIM ? YLIM : t.by;
		vx[2] = t.cx > XLIM ? XLIM : t.cx;
		vy[2] = t.cy > YLIM ? YLIM : t.cy;
		// compare-and-swap on (0,1), (1,2), (0,1)
		for (int i = 0; i < 3; i++) begin
			p = (i == 1) ? 1 : 0;
			if (vy[p] > vy[p+1]) begin
				tmp = vx[p]; vx[p] = vx[p+1]; vx[p+1] = tmp;
				tmp = vy[p]; vy[p] = vy[p+1]; vy[p+1] = tmp;
			end
		end
		n = 0;
		scan_half(vy[0], vy[1], vx[0], vy[0], edge_slope(vx[0], vy[0], vx[1], vy[1]),
			vx[0], vy[0], edge_slope(vx[0], vy[0], vx[2], vy[2]), n);
		scan_half(vy[1], vy[2], vx[1], vy[1], edge_slope(vx[1], vy[1], vx[2], vy[2]),
			vx[0], vy[0], edge_slope(vx[0], vy[0], vx[2], vy[2]), n);
		if (n > 0)
			span_q[$].span_last = 1'b1;
	endtask

	// Send one triangle; prediction happens at acceptance
	task automatic send_tri(vtx_item_t t);
		@(negedge clk);
		vtx       <= t;
		vtx_valid <= 1'b1;
		do @(posedge clk); while (!vtx_ready);
		predict_spans(t);
		@(negedge clk);
		vtx_valid <= 1'b0;
	endtask

	// Random gap between bursts
	task automatic maybe_gap(ref int burst);
		if (burst > 0) begin
			burst--;
		end else begin
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst = $urandom_range(0, 5);
		end
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (span_q.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (200) @(negedge clk);
	endtask

	function automatic vtx_item_t mk(int ax, int ay, int bx, int by, int cx, int cy);
		vtx_item_t t;
		t.ax = XW'(ax); t.ay = YW'(ay);
		t.bx = XW'(bx); t.by = YW'(by);
		t.cx = XW'(cx); t.cy = YW'(cy);
		return t;
	endfunction

	function automatic vtx_item_t rand_tri();
		vtx_item_t t;
		int        bx, by;
		case ($urandom_range(0, 9))
			0: t = vtx_item_t'({$urandom, $urandom, $urandom});
			1, 2: begin
				// small triangle near a random point
				bx = $urandom_range(0, 250000);
				by = $urandom_range(0, 14000);
				t = mk(bx + $urandom_range(0, 2000), by + $urandom_range(0, 1500),
					bx + $urandom_range(0, 2000), by + $urandom_range(0, 1500),
					bx + $urandom_range(0, 2000), by + $urandom_range(0, 1500));
			end
			default: t = mk($urandom_range(0, 261888), $urandom_range(0, 15872),
				$urandom_range(0, 261888), $urandom_range(0, 15872),
				$urandom_range(0, 261888), $urandom_range(0, 15872));
		endcase
		return t;
	endfunction

	// Corners, bounds, degenerate and special shapes
	task automatic test_directed();
		send_tri(mk(0, 0, 0, 0, 0, 0));
		send_tri(mk(261888, 15872, 0, 0, 0, 15872));
		send_tri(mk(2560, 512, 10240, 2048, 1280, 4096));
		send_tri(mk(2560, 2048, 10240, 512, 1280, 4096));
		send_tri(mk(2560, 1024, 10240, 1024, 5000, 3000));
		send_tri(mk(2560, 256, 10240, 3000, 5000, 3000));
		send_tri(mk(100, 100, 200, 150, 300, 200));
		send_tri(mk(1000, 1000, 1000, 1000, 1000, 1000));
		send_tri(mk(5000, 0, 5000, 10000, 5000, 15000));
		send_tri(mk(262143, 16383, 262143, 0, 0, 16383));
		send_tri(mk(0, 0, 262143, 16383, 131072, 8000));
		send_tri(mk(50000, 3000, 50100, 3010, 50050, 3005));
		send_tri(mk(0, 1, 300, 255, 100, 257));
		send_tri(mk(1023 << 8, 62 << 8, 0, 62 << 8, 512 << 8, 0));
		send_tri(mk(0, 0, 1023 << 8, 0, 512 << 8, 62 << 8));
		send_tri(mk('h2AAAA, 'h1555, 'h15555, 'h2AAA, 0, 'h3FFF));
	endtask

	task automatic test_random(int cnt);
		int burst;
		burst = 0;
		for (int i = 0; i < cnt; i++) begin
			maybe_gap(burst);
			send_tri(rand_tri());
		end
	endtask

	// Receiver holds off while triangles are offered, then sender waits for all spans and sends four random ones
	task automatic test_backpressure();
		hold_cycles = 400;
		for (int i = 0; i < 6; i++)
			send_tri(mk(0, 0, 200000, 100, 1000, 15800));
		drain();
		for (int i = 0; i < 4; i++)
			send_tri(rand_tri());
	endtask

	// Receiver stall pattern
	initial begin
		span_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				span_ready <= 1'b0;
			end else if (rx_random) begin
				span_ready <= ($urandom_range(0, 3) != 0);
			end else begin
				span_ready <= 1'b1;
			end
		end
	end

	// Stretches with and without stalls
	initial begin
		rx_random = 1'b0;
		forever begin
			repeat ($urandom_range(50, 600)) @(posedge clk);
			rx_random = ~rx_random;
		end
	end

	// Result checker
	always @(posedge clk) begin
		span_item_t e;
		if (arst_n && span_valid && span_ready) begin
			if (span_q.size() == 0) begin
				$display("%0t: unexpected span %p", $time, span);
				err_cnt++;
			end else begin
				e = span_q.pop_front();
				if (span.span_row !== e.span_row) begin
					$display("%0t: span_row exp %0d got %0d", $time, e.span_row, span.span_row);
					err_cnt++;
				end
				if (span.span_start !== e.span_start) begin
					$display("%0t: span_start exp %0d got %0d", $time, e.span_start,
						span.span_start);
					err_cnt++;
				end
				if (span.span_end !== e.span_end) begin
					$display("%0t: span_end exp %0d got %0d", $time, e.span_end, span.span_end);
					err_cnt++;
				end
				if (span.span_last !== e.span_last) begin
					$display("%0t: span_last exp %0d got %0d", $time, e.span_last,
						span.span_last);
					err_cnt++;
				end
			end
		end
	end

	// Main sequence
	initial begin
		err_cnt     = 0;
		hold_cycles = 0;
		arst_n      = 1'b0;
		vtx_valid   = 1'b0;
		vtx         = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random(140);
		drain();
		if (span_q.size() == 0 && err_cnt == 0) begin
			$display("** triangle_span_rasterizer_unit: PASSED **");
		end else begin
			$display("%0t: %0d spans still expected", $time, span_q.size());
			$display("** triangle_span_rasterizer_unit: FAILED **");
		end
		$finish;
	end

endmodule

>>> triangle_span_rasterizer_unit.f
rtl/tsru_pkg.sv
rtl/tsru_div.sv
rtl/triangle_span_rasterizer_unit.sv
dv/tb_top.sv
